// File: src/htfd_pkg.sv
package htfd_pkg;

  localparam int RAW_W        = 20;
  localparam int HUM_CENTI_W  = 14;
  localparam int TEMP_CENTI_W = 15;
  localparam int FRAC_BITS    = 20;

  localparam logic [7:0]              CRC_POLY    = 8'h31;
  localparam logic [7:0]              CRC_INIT    = 8'hFF;
  localparam logic [HUM_CENTI_W-1:0]  HUM_SCALE   = 14'd10000;
  localparam logic [TEMP_CENTI_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_CENTI_W-1:0] TEMP_OFFSET = 15'd5000;

  typedef enum logic [1:0] {
    CRC_NOT_CHECKED = 2'd0,
    CRC_MATCH       = 2'd1,
    CRC_MISMATCH    = 2'd2
  } crc_status_e;

  // Position of the next byte within the sensor frame.
  typedef enum logic [2:0] {
    POS_STATUS   = 3'd0,
    POS_HUM_HI   = 3'd1,
    POS_HUM_MID  = 3'd2,
    POS_SPLIT    = 3'd3,
    POS_TEMP_MID = 3'd4,
    POS_TEMP_LO  = 3'd5,
    POS_CRC      = 3'd6,
    POS_DONE     = 3'd7
  } byte_pos_e;

  typedef struct packed {
    logic [RAW_W-1:0] humidity_raw;
    logic [RAW_W-1:0] temperature_raw;
    crc_status_e      crc_status;
  } frame_t;

  // CRC-8, MSB first, no final xor.
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: src/htfd_if.sv
interface htfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_result_if;
  logic                                    valid;
  logic                                    ready;
  logic [htfd_pkg::RAW_W-1:0]              humidity_raw;
  logic [htfd_pkg::RAW_W-1:0]              temperature_raw;
  logic [htfd_pkg::HUM_CENTI_W-1:0]        humidity_centi;
  logic signed [htfd_pkg::TEMP_CENTI_W-1:0] temperature_centi;
  htfd_pkg::crc_status_e                   crc_status;

  modport source (output valid, output humidity_raw, output temperature_raw,
                  output humidity_centi, output temperature_centi, output crc_status,
                  input ready);
  modport sink   (input valid, input humidity_raw, input temperature_raw,
                  input humidity_centi, input temperature_centi, input crc_status,
                  output ready);
endinterface

interface htfd_cfg_if;
  logic valid;
  logic ready;
  logic crc_enable;

  modport source (output valid, output crc_enable, input ready);
  modport sink   (input valid, input crc_enable, output ready);
endinterface

// File: src/htfd_front.sv
module htfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  htfd_byte_if.sink         byte_i,
  htfd_cfg_if.sink          cfg_i,
  input  logic              queue_full_i,
  output logic              push_valid_o,
  output htfd_pkg::frame_t  push_data_o
);
  import htfd_pkg::*;

  logic             crc_en_q;
  byte_pos_e        pos_q, pos_d, pos_cur;
  logic [7:0]       crc_q, crc_d, crc_cur, crc_upd;
  logic [RAW_W-1:0] hum_q, hum_d, temp_q, temp_d;
  logic             accept;
  crc_status_e      status;
  logic [7:0]       b;

  assign byte_i.ready = !queue_full_i;
  assign cfg_i.ready  = 1'b1;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.data_byte;

  assign pos_cur = byte_i.frame_start ? POS_STATUS : pos_q;
  assign crc_cur = byte_i.frame_start ? CRC_INIT : crc_q;
  assign crc_upd = crc8_update(crc_cur, b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      crc_en_q <= cfg_i.crc_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_STATUS;
      crc_q <= CRC_INIT;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // Every raw bit is rewritten before a frame completes, so no reset or clear.
  always_ff @(posedge clk_i) begin
    hum_q  <= hum_d;
    temp_q <= temp_d;
  end

  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    hum_d        = hum_q;
    temp_d       = temp_q;
    push_valid_o = 1'b0;
    status       = CRC_NOT_CHECKED;
    if (accept) begin
      pos_d = pos_cur;
      crc_d = crc_cur;
      unique case (pos_cur)
        POS_STATUS: begin
          crc_d = crc_upd;
          pos_d = POS_HUM_HI;
        end
        POS_HUM_HI: begin
          crc_d          = crc_upd;
          hum_d[19:12]   = b;
          pos_d          = POS_HUM_MID;
        end
        POS_HUM_MID: begin
          crc_d          = crc_upd;
          hum_d[11:4]    = b;
          pos_d          = POS_SPLIT;
        end
        POS_SPLIT: begin
          crc_d          = crc_upd;
          hum_d[3:0]     = b[7:4];
          temp_d[19:16]  = b[3:0];
          pos_d          = POS_TEMP_MID;
        end
        POS_TEMP_MID: begin
          crc_d          = crc_upd;
          temp_d[15:8]   = b;
          pos_d          = POS_TEMP_LO;
        end
        POS_TEMP_LO: begin
          crc_d          = crc_upd;
          temp_d[7:0]    = b;
          if (crc_en_q) begin
            pos_d = POS_CRC;
          end else begin
            pos_d        = POS_DONE;
            push_valid_o = 1'b1;
          end
        end
        POS_CRC: begin
          pos_d        = POS_DONE;
          push_valid_o = 1'b1;
          status       = (b == crc_cur) ? CRC_MATCH : CRC_MISMATCH;
        end
        POS_DONE: begin
          // drop bytes until the next frame start
        end
        default: begin
          pos_d = POS_DONE;
        end
      endcase
    end
  end

  assign push_data_o = '{humidity_raw: hum_d, temperature_raw: temp_d, crc_status: status};

endmodule

// File: src/htfd_queue.sv
module htfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  htfd_pkg::frame_t  push_data_i,
  output logic              full_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output htfd_pkg::frame_t  pop_data_o
);
  import htfd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          entry_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            push, pop;

  assign full_o      = (count_q == CW'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = entry_q[rd_ptr_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/htfd_back.sv
module htfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  htfd_pkg::frame_t  in_data_i,
  output logic              in_ready_o,
  htfd_result_if.source     result_o
);
  import htfd_pkg::*;

  localparam int HPROD_W = RAW_W + HUM_CENTI_W;
  localparam int TPROD_W = RAW_W + TEMP_CENTI_W;

  logic                       a_valid_q;
  frame_t                     a_frame_q;
  logic [HPROD_W-1:0]         a_hprod_q;
  logic [TPROD_W-1:0]         a_tprod_q;
  logic                       a_ready, load_out;

  logic                       out_valid_q;
  frame_t                     out_frame_q;
  logic [HUM_CENTI_W-1:0]     out_hum_q;
  logic [TEMP_CENTI_W-1:0]    out_temp_q;
  logic [TEMP_CENTI_W-1:0]    temp_int;

  assign load_out   = !out_valid_q || result_o.ready;
  assign a_ready    = !a_valid_q || load_out;
  assign in_ready_o = a_ready;

  // Floor of the scaled value is the top bits of the product.
  assign temp_int = a_tprod_q[TPROD_W-1 -: TEMP_CENTI_W] - TEMP_OFFSET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (load_out) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_frame_q <= in_data_i;
      a_hprod_q <= HPROD_W'(in_data_i.humidity_raw) * HPROD_W'(HUM_SCALE);
      a_tprod_q <= TPROD_W'(in_data_i.temperature_raw) * TPROD_W'(TEMP_SCALE);
    end
    if (a_valid_q && load_out) begin
      out_frame_q <= a_frame_q;
      out_hum_q   <= a_hprod_q[HPROD_W-1 -: HUM_CENTI_W];
      out_temp_q  <= temp_int;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.humidity_raw      = out_frame_q.humidity_raw;
  assign result_o.temperature_raw   = out_frame_q.temperature_raw;
  assign result_o.humidity_centi    = out_hum_q;
  assign result_o.temperature_centi = $signed(out_temp_q);
  assign result_o.crc_status        = out_frame_q.crc_status;

endmodule

// File: src/humidity_temp_frame_decoder.sv
// Throughput: one byte per cycle while the frame queue has room; at most one result
//   per six (CRC off) or seven bytes. A frame enters a queue entry as its last byte
//   is accepted, then passes the multiplier register and the output register.
// The byte port stalls only when the frame queue is full, which needs a result-side stall.
// Reset (rst_ni low, asynchronous): crc_enable = 1, frame position at byte 0, CRC = 0xFF,
//   queue and pipeline empty.
module humidity_temp_frame_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  htfd_byte_if.sink     byte_i,
  htfd_cfg_if.sink      cfg_i,
  htfd_result_if.source result_o
);
  import htfd_pkg::*;

  // Front to queue: completed frames with raw codes and CRC verdict.
  logic   push_valid;
  frame_t push_data;
  logic   queue_full;

  // Queue to back end.
  logic   pop_valid;
  logic   pop_ready;
  frame_t pop_data;

  // Front: track byte position, run the CRC, assemble raw codes, and hand a
  // finished frame to the queue in the same cycle its last byte is accepted.
  htfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .cfg_i        (cfg_i),
    .queue_full_i (queue_full),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  // Short frame queue: lets the front keep taking bytes while a result waits.
  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .full_o       (queue_full),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: scale to hundredths (multiply, then shift and offset) and hold
  // the result until the sink takes it.
  htfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pop_valid),
    .in_data_i  (pop_data),
    .in_ready_o (pop_ready),
    .result_o   (result_o)
  );

endmodule

// File: src/htfd_checker.sv
module htfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [19:0] humidity_raw_i,
  input logic [19:0] temperature_raw_i,
  input logic [13:0] humidity_centi_i,
  input logic [14:0] temperature_centi_i,
  input logic [1:0]  crc_status_i
);

  logic [2:0] in_cnt_q;

  // Count accepted bytes since reset, saturating.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q <= '0;
    end else if (in_valid_i && in_ready_i && (in_cnt_q != 3'd7)) begin
      in_cnt_q <= in_cnt_q + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({humidity_raw_i, temperature_raw_i, humidity_centi_i,
               temperature_centi_i, crc_status_i}))
    else $error("result changed while stalled");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (in_cnt_q >= 3'd6))
    else $error("result before a full frame was accepted");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (byte_i.valid),
  .in_ready_i          (byte_i.ready),
  .out_valid_i         (result_o.valid),
  .out_ready_i         (result_o.ready),
  .humidity_raw_i      (result_o.humidity_raw),
  .temperature_raw_i   (result_o.temperature_raw),
  .humidity_centi_i    (result_o.humidity_centi),
  .temperature_centi_i (result_o.temperature_centi),
  .crc_status_i        (result_o.crc_status)
);

// File: tb/humidity_temp_frame_decoder_tb.sv
module humidity_temp_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htfd_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 4;
  // A result passes the queue entry, multiplier and output registers; give a little margin.
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 10;
  // Longest legal quiet spell is the forced receiver hold-off plus random stalls.
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 9;
  localparam int PHASE_BYTES    = 180;
  localparam int QUIET_PHASE    = 3;
  localparam int HOLD_PHASE     = 5;

  // One decoded sensor reading, as seen on the result channel.
  typedef struct packed {
    logic [RAW_W-1:0]               humidity_raw;
    logic [RAW_W-1:0]               temperature_raw;
    logic [HUM_CENTI_W-1:0]         humidity_centi;
    logic signed [TEMP_CENTI_W-1:0] temperature_centi;
    crc_status_e                    crc_status;
  } reading_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;
  // How the byte value of a directed row is formed: as typed, or from the frame CRC.
  typedef enum logic [1:0] {FILL_NONE, FILL_GOOD, FILL_BAD} crc_fill_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       first;    // frame_start for byte rows
    logic [7:0] value;    // byte value, or crc_enable in bit 0 for config rows
    crc_fill_e  fill;
    logic       typed;    // the reading below is what this byte must produce
    reading_t   reading;
  } stim_row_t;

  // Readings that follow straight from the conversion formulas at the code extremes.
  localparam reading_t ALL_ZERO_READING =
    '{20'h00000, 20'h00000, 14'd0, -15'sd5000, CRC_NOT_CHECKED};
  localparam reading_t ALL_ONES_READING =
    '{20'hFFFFF, 20'hFFFFF, 14'd9999, 15'sd14999, CRC_NOT_CHECKED};

  localparam int DIR_ROWS = 32;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // No start bit straight after reset: first byte is still taken as the status byte.
    '{ROW_BYTE, 1'b0, 8'h1C, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h6B, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h3A, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h95, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h5E, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h2F, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h00, FILL_GOOD, 1'b0, '0},
    // Trailing byte after a finished frame: must be dropped.
    '{ROW_BYTE, 1'b0, 8'hA5, FILL_NONE, 1'b0, '0},
    // Frame cut short by the next start bit.
    '{ROW_BYTE, 1'b1, 8'h5A, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'hC3, FILL_NONE, 1'b0, '0},
    '{ROW_CFG,  1'b0, 8'h00, FILL_NONE, 1'b0, '0},
    // Six-byte frames at both code extremes.
    '{ROW_BYTE, 1'b1, 8'h00, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h00, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h00, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h00, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h00, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h00, FILL_NONE, 1'b1, ALL_ZERO_READING},
    '{ROW_BYTE, 1'b1, 8'hFF, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'hFF, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'hFF, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'hFF, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'hFF, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'hFF, FILL_NONE, 1'b1, ALL_ONES_READING},
    // CRC switched on mid-frame, before byte 5: the frame grows a check byte.
    '{ROW_BYTE, 1'b1, 8'h80, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h7F, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h01, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'hFE, FILL_NONE, 1'b0, '0},
    '{ROW_CFG,  1'b0, 8'h01, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h40, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h02, FILL_NONE, 1'b0, '0},
    // Cleared again after byte 5: the check byte is still compared.
    '{ROW_CFG,  1'b0, 8'h00, FILL_NONE, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 8'h00, FILL_BAD,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  htfd_byte_if   byte_if ();
  htfd_cfg_if    cfg_if ();
  htfd_result_if res_if ();

  humidity_temp_frame_decoder u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .byte_i  (byte_if),
    .cfg_i   (cfg_if),
    .result_o(res_if)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame decoder prediction: position, running CRC, both raw codes and the
  // latched crc_enable, all updated at the edge that accepts a transaction.
  // ---------------------------------------------------------------------------
  byte_pos_e        rx_pos    = POS_STATUS;
  logic [7:0]       rx_crc    = CRC_INIT;
  logic [RAW_W-1:0] rx_hum    = '0;
  logic [RAW_W-1:0] rx_temp   = '0;
  logic             rx_crc_en = 1'b1;

  reading_t frames_due [$];

  // Stimulus-side bookkeeping.
  logic [7:0] tx_crc        = CRC_INIT;
  logic       cur_crc_en    = 1'b1;
  logic       typed_now     = 1'b0;
  reading_t   typed_reading = '0;
  int         byte_idle_pct = 20;
  int         res_stall_pct = 20;
  int         hold_off_cycles = 0;

  int bytes_sent   = 0;
  int cfg_writes   = 0;
  int frames_seen  = 0;
  int status_seen [3] = '{0, 0, 0};
  int error_count  = 0;
  int quiet_cycles = 0;

  // Bit-serial CRC-8, MSB first: shift each data bit through the register.
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ d[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Advance the frame state by one byte; raise produced when a reading is due.
  function automatic void decode_byte(input logic [7:0] d, input logic first,
                                      output bit produced, output reading_t r);
    logic [34:0] hum_prod;
    logic [34:0] temp_prod;
    crc_status_e status;
    produced = 1'b0;
    r        = '0;
    status   = CRC_NOT_CHECKED;
    if (first) begin
      rx_pos  = POS_STATUS;
      rx_crc  = CRC_INIT;
      rx_hum  = '0;
      rx_temp = '0;
    end
    case (rx_pos)
      POS_STATUS: begin
        rx_crc = crc8_next(rx_crc, d);
        rx_pos = POS_HUM_HI;
      end
      POS_HUM_HI: begin
        rx_crc         = crc8_next(rx_crc, d);
        rx_hum[19:12]  = d;
        rx_pos         = POS_HUM_MID;
      end
      POS_HUM_MID: begin
        rx_crc        = crc8_next(rx_crc, d);
        rx_hum[11:4]  = d;
        rx_pos        = POS_SPLIT;
      end
      POS_SPLIT: begin
        rx_crc          = crc8_next(rx_crc, d);
        rx_hum[3:0]     = d[7:4];
        rx_temp[19:16]  = d[3:0];
        rx_pos          = POS_TEMP_MID;
      end
      POS_TEMP_MID: begin
        rx_crc         = crc8_next(rx_crc, d);
        rx_temp[15:8]  = d;
        rx_pos         = POS_TEMP_LO;
      end
      POS_TEMP_LO: begin
        rx_crc        = crc8_next(rx_crc, d);
        rx_temp[7:0]  = d;
        // The enable is sampled here; later writes do not affect this frame.
        if (rx_crc_en) begin
          rx_pos = POS_CRC;
        end else begin
          rx_pos   = POS_DONE;
          produced = 1'b1;
        end
      end
      POS_CRC: begin
        rx_pos   = POS_DONE;
        produced = 1'b1;
        status   = (d == rx_crc) ? CRC_MATCH : CRC_MISMATCH;
      end
      default: begin
      end
    endcase
    if (produced) begin
      hum_prod            = 35'(rx_hum) * 35'(HUM_SCALE);
      temp_prod           = 35'(rx_temp) * 35'(TEMP_SCALE);
      r.humidity_raw      = rx_hum;
      r.temperature_raw   = rx_temp;
      r.humidity_centi    = hum_prod[FRAC_BITS +: HUM_CENTI_W];
      r.temperature_centi = temp_prod[FRAC_BITS +: TEMP_CENTI_W] - TEMP_OFFSET;
      r.crc_status        = status;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check results against the oldest due reading, then absorb config
  // and byte transactions into the prediction. Also runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t want;
    reading_t predicted;
    bit       produced;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        frames_seen++;
        if (res_if.crc_status <= CRC_MISMATCH) status_seen[res_if.crc_status]++;
        if (frames_due.size() == 0) begin
          $error("result transaction with no reading due");
          error_count++;
        end else begin
          want = frames_due.pop_front();
          if (res_if.humidity_raw !== want.humidity_raw) begin
            $error("humidity_raw: expected %0h, got %0h",
                   want.humidity_raw, res_if.humidity_raw);
            error_count++;
          end
          if (res_if.temperature_raw !== want.temperature_raw) begin
            $error("temperature_raw: expected %0h, got %0h",
                   want.temperature_raw, res_if.temperature_raw);
            error_count++;
          end
          if (res_if.humidity_centi !== want.humidity_centi) begin
            $error("humidity_centi: expected %0d, got %0d",
                   want.humidity_centi, res_if.humidity_centi);
            error_count++;
          end
          if (res_if.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi: expected %0d, got %0d",
                   want.temperature_centi, res_if.temperature_centi);
            error_count++;
          end
          if (res_if.crc_status !== want.crc_status) begin
            $error("crc_status: expected %0d, got %0d",
                   want.crc_status, res_if.crc_status);
            error_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved     = 1'b1;
        rx_crc_en = cfg_if.crc_enable;
      end
      if (byte_if.valid && byte_if.ready) begin
        moved = 1'b1;
        decode_byte(byte_if.data_byte, byte_if.frame_start, produced, predicted);
        // Directed rows may carry a hand-typed reading; use it in place of the prediction.
        if (produced) frames_due.push_back(typed_now ? typed_reading : predicted);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d readings still due",
             WATCHDOG_LIMIT, frames_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, or a counted hold-off when one is requested.
  // ---------------------------------------------------------------------------
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= res_stall_pct);
      end
    end
  end

  // Offer one byte, possibly after random idle cycles, and hold it until taken.
  // Enter and leave at a falling edge; valid stays high on return.
  task automatic send_byte(input logic [7:0] d, input logic first);
    while ($urandom_range(99) < byte_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    if (first) tx_crc = CRC_INIT;
    tx_crc = crc8_next(tx_crc, d);
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= d;
    byte_if.frame_start <= first;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Write crc_enable once the decoder is quiet: no reading due, pipeline drained.
  task automatic write_crc_enable(input logic en);
    byte_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.crc_enable <= en;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cur_crc_en = en;
    cfg_writes++;
  endtask

  // Byte content biased toward the extremes now and then.
  function automatic logic [7:0] sensor_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames with random codes; the rest truncated frames and noise.
  task automatic send_random_frame();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 75) begin
      send_byte(sensor_byte(), 1'b1);
      repeat (5) send_byte(sensor_byte(), 1'b0);
      if (cur_crc_en) begin
        if ($urandom_range(9) < 8) send_byte(tx_crc, 1'b0);
        else send_byte(sensor_byte(), 1'b0);
      end
    end else if (pick < 87) begin
      n = $urandom_range(5, 1);
      send_byte(sensor_byte(), 1'b1);
      repeat (n - 1) send_byte(sensor_byte(), 1'b0);
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) send_byte(sensor_byte(), ($urandom_range(3) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, randomized phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t  row;
    logic [7:0] value;
    int         phase_base;
    rst_n               = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.data_byte   = 8'h00;
    byte_if.frame_start = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.crc_enable   = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Walk the directed table; fill check bytes from the CRC of the bytes sent so far.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_CFG) begin
        write_crc_enable(row.value[0]);
      end else begin
        case (row.fill)
          FILL_GOOD: value = tx_crc;
          FILL_BAD:  value = ~tx_crc;
          default:   value = row.value;
        endcase
        typed_now     = row.typed;
        typed_reading = row.reading;
        send_byte(value, row.first);
      end
    end
    typed_now = 1'b0;

    // Random phases: alternate the CRC mode, drop idling and receiver stalls in one
    // phase and hold the receiver off in another so the frame queue backs up.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_crc_enable(ph[0] ? 1'b0 : 1'b1);
      byte_idle_pct = (ph == QUIET_PHASE) ? 0 : 20;
      res_stall_pct = (ph == QUIET_PHASE) ? 0 : 20;
      if (ph == HOLD_PHASE) hold_off_cycles = HOLD_OFF_LEN;
      phase_base = bytes_sent;
      while (bytes_sent - phase_base < PHASE_BYTES) send_random_frame();
    end

    byte_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d sensor bytes with %0d crc_enable writes; checked %0d readings.",
             bytes_sent, cfg_writes, frames_seen);
    $display("Readings by CRC status: %0d unchecked, %0d matched, %0d mismatched.",
             status_seen[CRC_NOT_CHECKED], status_seen[CRC_MATCH],
             status_seen[CRC_MISMATCH]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
